// ----- rtl/core/delta_coded_reloc_table_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Relocation table decoder assertion macros
// Shared property wrappers for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef DELTA_CODED_RELOC_TABLE_DECODER_TOP_MACROS_SVH
`define DELTA_CODED_RELOC_TABLE_DECODER_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define DCRTD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define DCRTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dcrtd_pkg.sv -----
// ----------------------------------------------------------------------------
// Relocation table decoder package
// Widths, codes and shared types of the decoder.
// ----------------------------------------------------------------------------
package dcrtd_pkg;

   localparam int OFFSET_BITS    = 24;
   localparam int OPO_W          = OFFSET_BITS + 1;
   localparam int SUM_W          = OFFSET_BITS + 2;
   localparam int RELOC_OFFSET_W = 24;
   localparam int BYTE_W         = 8;
   localparam int INDEX_W        = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 8;

   localparam logic [SUM_W-1:0]  OFFSET_LIMIT = SUM_W'(1) << OFFSET_BITS;
   localparam logic [BYTE_W-1:0] DELTA_END    = 8'd0;
   localparam logic [BYTE_W-1:0] DELTA_SKIP   = 8'd255;
   localparam logic [BYTE_W-1:0] SKIP_AMOUNT  = 8'd254;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UNDEF_SEG = 1'b0,
      CSR_AUX_MASK  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_DELTA     = 3'd0,
      PH_TYPE      = 3'd1,
      PH_SEG       = 3'd2,
      PH_IDXLO     = 3'd3,
      PH_IDXHI     = 3'd4,
      PH_AUX_NOIDX = 3'd5,
      PH_AUX_IDX   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] undefined_segment_id;
      logic [BYTE_W-1:0] aux_type_mask;
   } cfg_type;

   typedef struct packed {
      logic                      is_end;
      logic                      truncated;
      logic [RELOC_OFFSET_W-1:0] reloc_offset;
      logic                      offset_overflow;
      logic [BYTE_W-1:0]         reloc_type;
      logic [BYTE_W-1:0]         segment_id;
      logic                      has_symbol_index;
      logic [INDEX_W-1:0]        symbol_index;
      logic                      has_aux;
      logic [BYTE_W-1:0]         aux_low;
   } rsp_payload_type;

endpackage

// ----- rtl/core/dcrtd_req_if.sv -----
// ----------------------------------------------------------------------------
// Relocation table decoder request channel
// Valid/ready channel carrying one table byte per transaction.
// ----------------------------------------------------------------------------
interface dcrtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;
   logic       final_byte;

   modport source (output valid, output table_byte, output final_byte, input ready);
   modport sink   (input valid, input table_byte, input final_byte, output ready);
endinterface

// ----- rtl/core/dcrtd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Relocation table decoder response channel
// Valid/ready channel carrying one decoded record per transaction.
// ----------------------------------------------------------------------------
interface dcrtd_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_end;
   logic        truncated;
   logic [23:0] reloc_offset;
   logic        offset_overflow;
   logic [7:0]  reloc_type;
   logic [7:0]  segment_id;
   logic        has_symbol_index;
   logic [15:0] symbol_index;
   logic        has_aux;
   logic [7:0]  aux_low;

   modport source (
      output valid, output is_end, output truncated, output reloc_offset,
      output offset_overflow, output reloc_type, output segment_id,
      output has_symbol_index, output symbol_index, output has_aux, output aux_low,
      input ready
   );
   modport sink (
      input valid, input is_end, input truncated, input reloc_offset,
      input offset_overflow, input reloc_type, input segment_id,
      input has_symbol_index, input symbol_index, input has_aux, input aux_low,
      output ready
   );
endinterface

// ----- rtl/core/dcrtd_parser.sv -----
// ----------------------------------------------------------------------------
// Relocation table parser
// Phase tracking, offset accumulation and record assembly, one byte a cycle while accept is high.
// ----------------------------------------------------------------------------
module dcrtd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                table_byte,
   input  logic                      final_byte,
   input  dcrtd_pkg::cfg_type        cfg,
   output logic                      push,
   output dcrtd_pkg::rsp_payload_type push_data
);
   import dcrtd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [OPO_W-1:0]   opo_ff, opo_in;
   logic               sat_ff, sat_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  seg_ff, seg_in;
   logic [BYTE_W-1:0]  idx_low_ff, idx_low_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   logic [SUM_W-1:0]   sum;
   logic [BYTE_W-1:0]  amount;
   logic [OPO_W-1:0]   offset;
   logic               aux_follows;
   logic               ended;
   logic               emit;

   assign offset      = opo_ff - OPO_W'(1);
   assign amount      = (table_byte == DELTA_SKIP) ? SKIP_AMOUNT : table_byte;
   assign sum         = {1'b0, opo_ff} + SUM_W'(amount);
   assign aux_follows = (type_ff & cfg.aux_type_mask) != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELTA;
         opo_ff     <= '0;
         sat_ff     <= 1'b0;
         type_ff    <= '0;
         seg_ff     <= '0;
         idx_low_ff <= '0;
         idx_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         opo_ff     <= opo_in;
         sat_ff     <= sat_in;
         type_ff    <= type_in;
         seg_ff     <= seg_in;
         idx_low_ff <= idx_low_in;
         idx_ff     <= idx_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      opo_in     = opo_ff;
      sat_in     = sat_ff;
      type_in    = type_ff;
      seg_in     = seg_ff;
      idx_low_in = idx_low_ff;
      idx_in     = idx_ff;
      ended      = 1'b0;
      emit       = 1'b0;
      push_data  = '0;
      push_data.reloc_offset    = RELOC_OFFSET_W'(offset);
      push_data.offset_overflow = sat_ff;

      case (phase_ff)
         PH_TYPE: begin
            type_in  = table_byte;
            phase_in = PH_SEG;
         end
         PH_SEG: begin
            seg_in = table_byte;
            if (table_byte == cfg.undefined_segment_id) begin
               phase_in = PH_IDXLO;
            end else if (aux_follows) begin
               phase_in = PH_AUX_NOIDX;
            end else begin
               emit     = 1'b1;
               phase_in = PH_DELTA;
            end
         end
         PH_IDXLO: begin
            idx_low_in = table_byte;
            phase_in   = PH_IDXHI;
         end
         PH_IDXHI: begin
            idx_in = {table_byte, idx_low_ff};
            if (aux_follows) begin
               phase_in = PH_AUX_IDX;
            end else begin
               emit                       = 1'b1;
               push_data.has_symbol_index = 1'b1;
               push_data.symbol_index     = {table_byte, idx_low_ff};
               phase_in                   = PH_DELTA;
            end
         end
         PH_AUX_NOIDX, PH_AUX_IDX: begin
            emit              = 1'b1;
            push_data.has_aux = 1'b1;
            push_data.aux_low = table_byte;
            if (phase_ff == PH_AUX_IDX) begin
               push_data.has_symbol_index = 1'b1;
               push_data.symbol_index     = idx_ff;
            end
            phase_in = PH_DELTA;
         end
         default: begin
            // unused codes behave as "expecting a delta"
            phase_in = PH_DELTA;
            if (table_byte == DELTA_END) begin
               ended = 1'b1;
            end else begin
               if (sum > OFFSET_LIMIT) begin
                  opo_in = OFFSET_LIMIT[OPO_W-1:0];
                  sat_in = 1'b1;
               end else begin
                  opo_in = sum[OPO_W-1:0];
               end
               if (table_byte != DELTA_SKIP) begin
                  idx_in     = '0;
                  idx_low_in = '0;
                  phase_in   = PH_TYPE;
               end
            end
         end
      endcase

      push_data.reloc_type = type_in;
      push_data.segment_id = seg_in;

      if (!emit) begin
         push_data = '0;
      end
      push = emit;

      if (ended) begin
         push_data        = '0;
         push_data.is_end = 1'b1;
         push             = 1'b1;
      end

      // end marker and truncation both restart the table
      if (ended || final_byte) begin
         phase_in   = PH_DELTA;
         opo_in     = '0;
         sat_in     = 1'b0;
         type_in    = '0;
         seg_in     = '0;
         idx_low_in = '0;
         idx_in     = '0;
      end

      if (final_byte && !ended) begin
         push_data           = '0;
         push_data.truncated = 1'b1;
         push                = 1'b1;
      end
   end

endmodule

// ----- rtl/core/dcrtd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Relocation table decoder output stage
// Output register plus skid register decoupling the parser from stalls.
// ----------------------------------------------------------------------------
module dcrtd_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcrtd_pkg::rsp_payload_type push_data,
   output logic                       space_ok,
   dcrtd_rsp_if.source                rsp_ch
);
   import dcrtd_pkg::*;

   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            pop;

   assign pop      = out_valid_ff && rsp_ch.ready;
   assign space_ok = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no push possible here: space_ok is low
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.is_end           = out_ff.is_end;
   assign rsp_ch.truncated        = out_ff.truncated;
   assign rsp_ch.reloc_offset     = out_ff.reloc_offset;
   assign rsp_ch.offset_overflow  = out_ff.offset_overflow;
   assign rsp_ch.reloc_type       = out_ff.reloc_type;
   assign rsp_ch.segment_id       = out_ff.segment_id;
   assign rsp_ch.has_symbol_index = out_ff.has_symbol_index;
   assign rsp_ch.symbol_index     = out_ff.symbol_index;
   assign rsp_ch.has_aux          = out_ff.has_aux;
   assign rsp_ch.aux_low          = out_ff.aux_low;

endmodule

// ----- rtl/core/delta_coded_reloc_table_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Delta-coded relocation table decoder
// Turns a byte stream of a relocation table into relocation records.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one table byte per transaction plus a flag marking the
//    last byte of the stream; rsp_ch carries at most one record per byte.
//  - csr_wr_en/csr_index/csr_wr_data write the undefined-segment id (index 0)
//    and the aux type mask (index 1); write them only while the block is idle.
//  - Throughput: one byte per cycle while the skid register has room. The parser
//    state updates in the same cycle a byte is taken; the record lands in the
//    output register, or in the skid register while the output register
//    holds a stalled record.
//  - A zero delta yields an end marker, a final byte mid-table yields a
//    truncation transaction; both restart the offset at minus one.
//  - Reset (synchronous, active high) clears the parser to "expecting a
//    delta", the offset to minus one and both registers to zero.
//  - When the receiver stalls, the output register holds its record and a
//    skid register takes one more; req_ch.ready drops only once the skid
//    register is full, so no transaction is lost.
// ----------------------------------------------------------------------------
module delta_coded_reloc_table_decoder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   dcrtd_req_if.sink                              req_ch,
   dcrtd_rsp_if.source                            rsp_ch,
   input  logic                                   csr_wr_en,
   input  logic [dcrtd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dcrtd_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import dcrtd_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            accept;
   logic            space_ok;
   logic            push;
   rsp_payload_type push_data;

   // Configuration registers: take the write on the enable, no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_UNDEF_SEG: cfg_in.undefined_segment_id = csr_wr_data;
            CSR_AUX_MASK:  cfg_in.aux_type_mask        = csr_wr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Accept whenever the skid register has room, independent of rsp_ch.ready.
   assign req_ch.ready = space_ok;
   assign accept       = req_ch.valid && space_ok;

   dcrtd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .table_byte (req_ch.table_byte),
      .final_byte (req_ch.final_byte),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data)
   );

   // Advance the record only on a transaction; drop nothing on stall.
   dcrtd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push && accept),
      .push_data (push_data),
      .space_ok  (space_ok),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- rtl/core/dcrtd_checker.sv -----
// ----------------------------------------------------------------------------
// Relocation table decoder checker
// Port-level properties of the decoder response channel.
// ----------------------------------------------------------------------------
`include "delta_coded_reloc_table_decoder_top_macros.svh"

module dcrtd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        is_end,
   input logic        truncated,
   input logic [23:0] reloc_offset,
   input logic [7:0]  reloc_type,
   input logic        has_symbol_index,
   input logic [15:0] symbol_index,
   input logic        has_aux,
   input logic [7:0]  aux_low
);

   `DCRTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `DCRTD_ASSERT_NOW(a_marker_excl, clock, reset, rsp_valid, !(is_end && truncated), "end marker and truncation together")

   `DCRTD_ASSERT_NOW(a_marker_clean, clock, reset, rsp_valid && (is_end || truncated), reloc_offset == 24'd0 && reloc_type == 8'd0 && !has_symbol_index && !has_aux, "marker carries record fields")

   `DCRTD_ASSERT_NOW(a_absent_zero, clock, reset, rsp_valid, (has_aux || aux_low == 8'd0) && (has_symbol_index || symbol_index == 16'd0), "absent field not zero")

endmodule

bind delta_coded_reloc_table_decoder_top dcrtd_checker u_dcrtd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .is_end           (rsp_ch.is_end),
   .truncated        (rsp_ch.truncated),
   .reloc_offset     (rsp_ch.reloc_offset),
   .reloc_type       (rsp_ch.reloc_type),
   .has_symbol_index (rsp_ch.has_symbol_index),
   .symbol_index     (rsp_ch.symbol_index),
   .has_aux          (rsp_ch.has_aux),
   .aux_low          (rsp_ch.aux_low)
);
